@@ hdl/gpars_pkg.sv @@
// Package for the grid point add / rectangle sum block.
// Holds shared constants and types; no dependencies.
package gpars_pkg;
	localparam int GRID_SIDE_DEF = 256;
	localparam int COORD_W = 8;
	localparam int CFG_W = 9;
	localparam int SUM_W = 32;
	localparam int DELTA_W = 16;
	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;
endpackage

@@ hdl/gpars_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module gpars_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/grid_point_add_rectangle_sum.sv @@
// Grid point add / rectangle sum: a 2D Fenwick array in one RAM, cleared by a
// sweep of GRID_SIDE*GRID_SIDE words after reset during which no transfer is taken.
// An add walks up to (log2(side)+1)^2 entries, each read and then written back
// (read state, then write-back state); a query walks four prefixes of up to
// log2(side)^2 entries, one a cycle. The single RAM port pair sets the rate.
// Depends on gpars_pkg and gpars_ram.
module grid_point_add_rectangle_sum #(
	parameter int GRID_SIDE = gpars_pkg::GRID_SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // x_low, y_low, x_high, y_high, delta
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // rect_sum
);
	localparam int AW = $clog2(GRID_SIDE);
	localparam int IW = AW + 1;
	localparam int DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int MW = 2 * AW;
	localparam int CFG_W_L = gpars_pkg::CFG_W;
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_ADD_RD = 3'd2;
	localparam logic [2:0] ST_ADD_WR = 3'd3;
	localparam logic [2:0] ST_Q_RUN = 3'd4;
	localparam logic [2:0] ST_Q_LAST = 3'd5;
	localparam logic [2:0] ST_OUT = 3'd6;

	logic [2:0] state_q;
	logic [CFG_W_L-1:0] gsz_q;
	logic [MW-1:0] clr_q;
	logic [IW-1:0] i_q, j_q, jst_q;
	logic [IW-1:0] xl_q, yl_q, xh_q, yh_q;
	logic [31:0] delta_q, acc_q, sum_q;
	logic [1:0] pfx_q;
	logic        pend_q;
	logic        pneg_q;
	logic        rd_q, rdneg_q;
	logic [31:0] rdata;
	logic        we;
	logic [MW-1:0] waddr, raddr;
	logic [31:0] wdata;

	function automatic logic [IW-1:0] clampc(input logic [7:0] v, input logic [8:0] g);
		logic [15:0] t;
		t = ({8'd0, v} > {7'd0, g} - 16'd1) ? {7'd0, g} - 16'd1 : {8'd0, v};
		return t[IW-1:0];
	endfunction

	gpars_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [IW-1:0] i_low, j_low, pi, pj;
	logic [IW:0] i_nx, j_nx;
	assign i_low = i_q & (i_q - 1'b1);
	assign j_low = j_q & (j_q - 1'b1);
	assign i_nx = {1'b0, i_q} + {1'b0, i_q & (~i_q + 1'b1)};
	assign j_nx = {1'b0, j_q} + {1'b0, j_q & (~j_q + 1'b1)};
	assign pi = i_q - 1'b1;
	assign pj = j_q - 1'b1;

	assign raddr = {pi[AW-1:0], pj[AW-1:0]};
	assign we = (state_q == ST_CLEAR) || (state_q == ST_ADD_WR);
	assign waddr = (state_q == ST_CLEAR) ? clr_q : {pi[AW-1:0], pj[AW-1:0]};
	assign wdata = (state_q == ST_CLEAR) ? 32'd0 : rdata + delta_q;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata = sum_q;

	// prefix corner selection for pfx index
	logic [IW-1:0] ci, cj;
	logic [8:0] gsz_e;
	always_comb begin
		unique case (pfx_q)
			2'd0: begin ci = xh_q + 1'b1; cj = yh_q + 1'b1; end
			2'd1: begin ci = xl_q; cj = yh_q + 1'b1; end
			2'd2: begin ci = xh_q + 1'b1; cj = yl_q; end
			default: begin ci = xl_q; cj = yl_q; end
		endcase
		gsz_e = (cfg_wdata == 9'd0) ? 9'd1 :
			({23'd0, cfg_wdata} > GRID_SIDE) ? 9'(GRID_SIDE) : cfg_wdata;
	end

	logic [IW-1:0] ci_next, cj_next;
	always_comb begin
		unique case (pfx_q)
			2'd0: begin ci_next = xl_q; cj_next = yh_q + 1'b1; end
			2'd1: begin ci_next = xh_q + 1'b1; cj_next = yl_q; end
			default: begin ci_next = xl_q; cj_next = yl_q; end
		endcase
	end

	logic [31:0] acc_n;
	assign acc_n = rd_q ? (rdneg_q ? acc_q - rdata : acc_q + rdata) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			gsz_q <= 9'(GRID_SIDE);
			rd_q <= 1'b0;
			rdneg_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			jst_q <= '0;
			xl_q <= '0;
			yl_q <= '0;
			xh_q <= '0;
			yh_q <= '0;
			delta_q <= '0;
			acc_q <= '0;
			sum_q <= '0;
			pfx_q <= '0;
			pend_q <= 1'b0;
			pneg_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				gsz_q <= gsz_e;
			end
			rd_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						xl_q <= clampc(s_tdata[7:0], gsz_q);
						yl_q <= clampc(s_tdata[15:8], gsz_q);
						xh_q <= clampc(s_tdata[23:16], gsz_q);
						yh_q <= clampc(s_tdata[31:24], gsz_q);
						delta_q <= {{16{s_tdata[47]}}, s_tdata[47:32]};
						if (s_tuser == gpars_pkg::CMD_ADD) begin
							i_q <= clampc(s_tdata[7:0], gsz_q) + 1'b1;
							j_q <= clampc(s_tdata[15:8], gsz_q) + 1'b1;
							jst_q <= clampc(s_tdata[15:8], gsz_q) + 1'b1;
							state_q <= ST_ADD_RD;
						end else begin
							pfx_q <= 2'd0;
							pend_q <= 1'b0;
							acc_q <= '0;
							state_q <= ST_Q_LAST;
						end
					end
				end
				ST_ADD_RD: state_q <= ST_ADD_WR;
				ST_ADD_WR: begin
					if (j_nx <= (IW+1)'(GRID_SIDE)) begin
						j_q <= j_nx[IW-1:0];
						state_q <= ST_ADD_RD;
					end else if (i_nx <= (IW+1)'(GRID_SIDE)) begin
						i_q <= i_nx[IW-1:0];
						j_q <= jst_q;
						state_q <= ST_ADD_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_Q_RUN: begin
					acc_q <= acc_n;
					rd_q <= (i_q != '0) && (j_q != '0);
					rdneg_q <= pneg_q;
					if (i_q == '0 || j_q == '0) begin
						state_q <= ST_Q_LAST;
					end else if (j_low != '0) begin
						j_q <= j_low;
					end else begin
						i_q <= i_low;
						j_q <= jst_q;
						if (i_low == '0) state_q <= ST_Q_LAST;
					end
				end
				ST_Q_LAST: begin
					// start the next prefix walk, or finish after the fourth
					acc_q <= acc_n;
					if (pend_q && pfx_q == 2'd3) begin
						state_q <= ST_OUT;
						sum_q <= (xl_q <= xh_q && yl_q <= yh_q) ? acc_n : 32'd0;
					end else begin
						if (pend_q) pfx_q <= pfx_q + 1'b1;
						pend_q <= 1'b1;
						i_q <= pend_q ? ci_next : ci;
						j_q <= pend_q ? cj_next : cj;
						jst_q <= pend_q ? cj_next : cj;
						pneg_q <= pend_q ? (pfx_q == 2'd0 || pfx_q == 2'd1) : 1'b0;
						state_q <= ST_Q_RUN;
					end
				end
				ST_OUT: if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ tb/sv/grid_point_add_rectangle_sum_tb.sv @@
// Testbench for grid_point_add_rectangle_sum: random adds and rectangle queries
// checked against a plain cell array kept by a scoreboard class.
// Depends on gpars_pkg and the block's RTL.
module grid_point_add_rectangle_sum_tb;

	class rect_sum_board;
		int unsigned side;
		logic [31:0] cells [0:255][0:255];
		logic [31:0] sums_due [$];
		int errors;

		function new();
			side = 256;
			errors = 0;
			foreach (cells[i, j]) cells[i][j] = '0;
		endfunction

		function void set_side(logic [8:0] v);
			side = (v == 0) ? 1 : (v > 256 ? 256 : v);
		endfunction

		function int unsigned clamp(logic [7:0] c);
			return (c > side - 1) ? side - 1 : c;
		endfunction

		function void note_item(logic cmd, logic [7:0] xl, logic [7:0] yl,
				logic [7:0] xh, logic [7:0] yh, logic signed [15:0] d);
			int unsigned a, b, c, e;
			logic [31:0] s;
			a = clamp(xl);
			b = clamp(yl);
			c = clamp(xh);
			e = clamp(yh);
			s = '0;
			if (cmd == gpars_pkg::CMD_ADD) begin
				cells[a][b] = cells[a][b] + {{16{d[15]}}, d};
			end else begin
				if (a <= c && b <= e) begin
					for (int i = a; i <= c; i++)
						for (int j = b; j <= e; j++)
							s = s + cells[i][j];
				end
				sums_due.push_back(s);
			end
		endfunction

		function void check_sum(logic [31:0] got);
			logic [31:0] want;
			if (sums_due.size() == 0) begin
				$display("%0t: unexpected sum %0d", $time, $signed(got));
				errors++;
			end else begin
				want = sums_due.pop_front();
				if (want !== got) begin
					$display("%0t: rect_sum expected %0d actual %0d", $time,
						$signed(want), $signed(got));
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [8:0] cfg_wdata = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [31:0] m_tdata;
	bit calm = 0;
	rect_sum_board board;

	always #5 clk = ~clk;

	grid_point_add_rectangle_sum DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			board.check_sum(m_tdata);
		m_tready <= calm || ($urandom_range(99) >= 12);
	end

	task automatic send_item(logic cmd, logic [7:0] xl, logic [7:0] yl,
			logic [7:0] xh, logic [7:0] yh, logic [15:0] d);
		while (!calm && $urandom_range(99) < 12) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= {d, yh, xh, yl, xl};
		do @(posedge clk); while (!s_tready);
		board.note_item(cmd, xl, yl, xh, yh, d);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.sums_due.size() != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
	endtask

	task automatic write_side(logic [8:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		board.set_side(v);
	endtask

	function automatic logic [7:0] coord(int unsigned lim);
		return ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(lim));
	endfunction

	task automatic random_items(int n, int unsigned lim);
		logic [7:0] a, b;
		for (int k = 0; k < n; k++) begin
			a = coord(lim);
			b = coord(lim);
			if ($urandom_range(1))
				send_item(gpars_pkg::CMD_ADD, a, b, 8'($urandom), 8'($urandom),
					16'($urandom));
			else
				send_item(gpars_pkg::CMD_QUERY, a, b, coord(lim), coord(lim),
					16'($urandom));
		end
	endtask

	initial begin
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_item(gpars_pkg::CMD_ADD, 0, 0, 8'hff, 8'hff, 16'h7fff);
		send_item(gpars_pkg::CMD_ADD, 255, 255, 0, 0, 16'h8000);
		send_item(gpars_pkg::CMD_ADD, 255, 0, 0, 0, 16'hffff);
		send_item(gpars_pkg::CMD_ADD, 0, 255, 0, 0, 16'h0001);
		send_item(gpars_pkg::CMD_QUERY, 0, 0, 255, 255, 16'hffff);
		send_item(gpars_pkg::CMD_QUERY, 255, 255, 255, 255, 0);
		send_item(gpars_pkg::CMD_QUERY, 10, 0, 9, 255, 0);
		send_item(gpars_pkg::CMD_QUERY, 0, 10, 255, 9, 0);
		send_item(gpars_pkg::CMD_QUERY, 0, 0, 0, 0, 0);
		drain();
		write_side(9'd0);
		send_item(gpars_pkg::CMD_ADD, 200, 100, 0, 0, 16'h0005);
		send_item(gpars_pkg::CMD_QUERY, 255, 255, 0, 0, 0);
		send_item(gpars_pkg::CMD_QUERY, 0, 0, 255, 255, 0);
		drain();
		write_side(9'h1ff);
		send_item(gpars_pkg::CMD_QUERY, 0, 0, 255, 255, 0);
		drain();
		write_side(9'd5);
		send_item(gpars_pkg::CMD_ADD, 9, 2, 0, 0, 16'h0100);
		send_item(gpars_pkg::CMD_QUERY, 4, 0, 200, 200, 0);
		send_item(gpars_pkg::CMD_QUERY, 3, 0, 2, 4, 0);
		drain();
		write_side(9'd16);
		random_items(150, 15);
		drain();
		write_side(9'd256);
		calm = 1;
		random_items(60, 255);
		calm = 0;
		random_items(60, 255);
		drain();
		write_side(9'd1);
		random_items(30, 3);
		drain();
		write_side(9'd37);
		random_items(100, 40);
		drain();
		if (board.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
